FILE: sv/kzn_pkg.sv
// Shared types, constants and functions of the GOST 34.12-2015 encryption block.
// S-box, linear-transform matrix, round constants, command and status structs.
// No dependencies.
`default_nettype none
package kzn_pkg;

	// Byte 0 is the most significant byte of every 128-bit value
	typedef logic [0:15][7:0] blk_t;
	typedef logic [0:15][0:15][7:0] mat_t;

	localparam int BlkW = 128;
	localparam int WordW = 64;
	localparam int RkCount = 10;
	localparam int LastRnd = 8;
	localparam int KxSteps = 32;

	// Configuration register indexes
	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_MODE = 3'd4;

	// Chaining modes
	localparam logic [2:0] MODE_ECB = 3'd0;
	localparam logic [2:0] MODE_CTR = 3'd1;
	localparam logic [2:0] MODE_OFB = 3'd2;
	localparam logic [2:0] MODE_CBC = 3'd3;
	localparam logic [2:0] MODE_CFB = 3'd4;

	// Item functions
	localparam logic [1:0] FN_BLOCK = 2'd0;
	localparam logic [1:0] FN_LOADA = 2'd1;
	localparam logic [1:0] FN_LOADB = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       take;     // input item accepted this cycle
		logic       kx_load;  // load key words into the Feistel halves
		logic       kx_step;  // one Feistel step of key expansion
		logic       enc_step; // one full round on the state
		logic       finish;   // last round, write result and feedback
		logic [4:0] cnt;      // step or round index
	} cmd_t;

	typedef struct packed {
		logic mode_ok;
	} stat_t;

	localparam logic [7:0] PI [256] = '{
		252,238,221,17,207,110,49,22,251,196,250,218,35,197,4,77,
		233,119,240,219,147,46,153,186,23,54,241,187,20,205,95,193,
		249,24,101,90,226,92,239,33,129,28,60,66,139,1,142,79,
		5,132,2,174,227,106,143,160,6,11,237,152,127,212,211,31,
		235,52,44,81,234,200,72,171,242,42,104,162,253,58,206,204,
		181,112,14,86,8,12,118,18,191,114,19,71,156,183,93,135,
		21,161,150,41,16,123,154,199,243,145,120,111,157,158,178,177,
		50,117,25,61,255,53,138,126,109,84,198,128,195,189,13,87,
		223,245,36,169,62,168,67,201,215,121,214,246,124,34,185,3,
		224,15,236,222,122,148,176,188,220,232,40,80,78,51,10,74,
		167,151,96,115,30,0,98,68,26,184,56,130,100,159,38,65,
		173,69,70,146,39,94,85,47,140,163,165,125,105,213,149,59,
		7,88,179,64,134,172,29,247,48,55,107,228,136,217,231,137,
		225,27,131,73,76,63,248,254,141,83,170,144,202,216,133,97,
		32,113,103,164,45,43,9,91,203,155,37,208,190,229,108,82,
		89,166,116,210,230,244,180,192,209,102,175,194,57,75,99,182
	};

	localparam logic [7:0] LIN_COEF [16] = '{
		148,32,133,16,194,192,1,251,1,192,194,16,133,32,148,1
	};

	// GF(2^8) multiply, polynomial 0xC3
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = '0;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc = acc ^ x;
			x = x[7] ? ((x << 1) ^ 8'hC3) : (x << 1);
		end
		return acc;
	endfunction

	// Matrix of the 16-step linear transform; row i is the image of unit byte i
	function automatic mat_t lin_mat();
		mat_t m;
		blk_t v;
		logic [7:0] s;
		for (int c = 0; c < 16; c++) begin
			v = '0;
			v[c] = 8'd1;
			for (int r = 0; r < 16; r++) begin
				s = '0;
				for (int i = 0; i < 16; i++) s = s ^ gf_mul(v[i], LIN_COEF[i]);
				v = {s, v[0:14]};
			end
			m[c] = v;
		end
		return m;
	endfunction

	localparam mat_t LMAT = lin_mat();

	// Linear transform as a flat XOR network
	function automatic blk_t lin_apply(input blk_t x);
		blk_t y;
		for (int j = 0; j < 16; j++) begin
			y[j] = '0;
			for (int i = 0; i < 16; i++) y[j] = y[j] ^ gf_mul(x[i], LMAT[i][j]);
		end
		return y;
	endfunction

	function automatic blk_t sub_bytes(input blk_t x);
		blk_t y;
		for (int i = 0; i < 16; i++) y[i] = PI[x[i]];
		return y;
	endfunction

	// Key schedule constant for step j: L of the counter j+1 in byte 15
	function automatic blk_t rcon(input logic [4:0] j);
		blk_t y;
		logic [7:0] n;
		n = 8'(j) + 8'd1;
		for (int k = 0; k < 16; k++) y[k] = gf_mul(n, LMAT[15][k]);
		return y;
	endfunction

endpackage
`default_nettype wire

FILE: sv/kzn_if.sv
// Valid/ready channel interfaces for input and result items.
// No dependencies.
`default_nettype none
interface kzn_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [63:0] block_high;
	logic [63:0] block_low;
	modport source (output valid, func, block_high, block_low, input ready);
	modport sink (input valid, func, block_high, block_low, output ready);
endinterface

interface kzn_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;
	modport source (output valid, result_high, result_low, input ready);
	modport sink (input valid, result_high, result_low, output ready);
endinterface
`default_nettype wire

FILE: sv/kzn_ctrl.sv
// Controller: key expansion sequencing, round counting and handshakes.
// Depends on kzn_pkg.
`default_nettype none
module kzn_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          key_wr,
	input  wire logic          in_valid,
	input  wire logic [1:0]    in_func,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire kzn_pkg::stat_t stat,
	output kzn_pkg::cmd_t      cmd
);
	localparam logic [1:0] S_KLOAD = 2'd0;
	localparam logic [1:0] S_KEXP  = 2'd1;
	localparam logic [1:0] S_IDLE  = 2'd2;
	localparam logic [1:0] S_ENC   = 2'd3;

	logic [1:0] state_q;
	logic [4:0] cnt_q;
	logic       ov_q;
	logic       take;
	logic       finish;

	assign in_ready = (state_q == S_IDLE) && !key_wr;
	assign take = in_valid && in_ready;
	assign finish = (state_q == S_ENC) && (cnt_q == 5'(kzn_pkg::LastRnd))
		&& (!ov_q || out_ready);
	assign out_valid = ov_q;

	// Command decode
	always_comb begin
		cmd.take = take;
		cmd.kx_load = (state_q == S_KLOAD);
		cmd.kx_step = (state_q == S_KEXP);
		cmd.enc_step = (state_q == S_ENC) && (cnt_q != 5'(kzn_pkg::LastRnd));
		cmd.finish = finish;
		cmd.cnt = cnt_q;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_KLOAD;
			cnt_q <= '0;
		end else if (key_wr) begin
			state_q <= S_KLOAD;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_KLOAD: begin
					state_q <= S_KEXP;
					cnt_q <= '0;
				end
				S_KEXP: begin
					if (cnt_q == 5'(kzn_pkg::KxSteps - 1)) state_q <= S_IDLE;
					cnt_q <= cnt_q + 5'd1;
				end
				S_IDLE: begin
					cnt_q <= '0;
					if (take && in_func == kzn_pkg::FN_BLOCK && stat.mode_ok)
						state_q <= S_ENC;
				end
				S_ENC: begin
					if (finish) state_q <= S_IDLE;
					else if (cnt_q != 5'(kzn_pkg::LastRnd)) cnt_q <= cnt_q + 5'd1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (finish) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end
endmodule
`default_nettype wire

FILE: sv/kzn_dpath.sv
// Datapath: config registers, round keys, shared LSX round unit, feedback slots.
// Depends on kzn_pkg.
`default_nettype none
module kzn_dpath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_idx,
	input  wire logic [63:0]   cfg_data,
	input  wire logic [1:0]    func,
	input  wire logic [63:0]   block_high,
	input  wire logic [63:0]   block_low,
	input  wire kzn_pkg::cmd_t cmd,
	output kzn_pkg::stat_t     stat,
	output logic [63:0]        result_high,
	output logic [63:0]        result_low
);
	logic [63:0]   kw_q [4];
	logic [2:0]    mode_q;
	logic [127:0]  rk_q [kzn_pkg::RkCount];
	logic [127:0]  st_q;
	logic [127:0]  aux_q;
	logic [127:0]  p_q;
	logic [127:0]  fa_q;
	logic [127:0]  fb_q;
	logic [127:0]  res_q;
	logic [127:0]  rkey;
	logic [127:0]  lsx;
	logic [127:0]  kx_next;
	logic [127:0]  enc_out;
	logic [127:0]  pin;
	logic [3:0]    rk_idx;

	assign stat.mode_ok = (mode_q <= kzn_pkg::MODE_CFB);
	assign pin = {block_high, block_low};
	assign result_high = res_q[127:64];
	assign result_low = res_q[63:0];

	// Shared round: S-box and linear transform on state xor key
	assign rkey = cmd.kx_step ? 128'(kzn_pkg::rcon(cmd.cnt)) : rk_q[cmd.cnt[3:0]];
	assign lsx = 128'(kzn_pkg::lin_apply(kzn_pkg::sub_bytes(kzn_pkg::blk_t'(st_q ^ rkey))));
	assign kx_next = lsx ^ aux_q;
	assign enc_out = lsx ^ rk_q[kzn_pkg::RkCount - 1];
	assign rk_idx = 4'({cmd.cnt[4:3], 1'b0}) + 4'd2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) kw_q[i] <= '0;
			mode_q <= kzn_pkg::MODE_ECB;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				kzn_pkg::REG_KEY0: kw_q[0] <= cfg_data;
				kzn_pkg::REG_KEY1: kw_q[1] <= cfg_data;
				kzn_pkg::REG_KEY2: kw_q[2] <= cfg_data;
				kzn_pkg::REG_KEY3: kw_q[3] <= cfg_data;
				kzn_pkg::REG_MODE: mode_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Round state, key schedule halves and round keys
	always_ff @(posedge clk) begin
		if (cmd.kx_load) begin
			st_q <= {kw_q[0], kw_q[1]};
			aux_q <= {kw_q[2], kw_q[3]};
			rk_q[0] <= {kw_q[0], kw_q[1]};
			rk_q[1] <= {kw_q[2], kw_q[3]};
		end else if (cmd.kx_step) begin
			st_q <= kx_next;
			aux_q <= st_q;
			if (cmd.cnt[2:0] == 3'd7) begin
				rk_q[rk_idx] <= kx_next;
				rk_q[rk_idx + 4'd1] <= st_q;
			end
		end else if (cmd.take && func == kzn_pkg::FN_BLOCK) begin
			p_q <= pin;
			case (mode_q)
				kzn_pkg::MODE_ECB: st_q <= pin;
				kzn_pkg::MODE_CBC: st_q <= pin ^ fa_q;
				default: st_q <= fa_q;
			endcase
		end else if (cmd.enc_step) begin
			st_q <= lsx;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (mode_q == kzn_pkg::MODE_ECB || mode_q == kzn_pkg::MODE_CBC) res_q <= enc_out;
			else res_q <= p_q ^ enc_out;
		end
	end

	// Feedback slots and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fa_q <= '0;
			fb_q <= '0;
		end else if (cmd.take && func == kzn_pkg::FN_LOADA) begin
			fa_q <= {block_high, (mode_q == kzn_pkg::MODE_CTR) ? 64'd0 : block_low};
		end else if (cmd.take && func == kzn_pkg::FN_LOADB) begin
			fb_q <= pin;
		end else if (cmd.finish) begin
			unique case (mode_q)
				kzn_pkg::MODE_CTR: begin
					fa_q[63:0] <= fa_q[63:0] + 64'd1;
					if (&fa_q[63:0]) fa_q[119:64] <= fa_q[119:64] + 56'd1;
				end
				kzn_pkg::MODE_OFB: begin
					fa_q <= fb_q;
					fb_q <= enc_out;
				end
				kzn_pkg::MODE_CBC: begin
					fa_q <= fb_q;
					fb_q <= enc_out;
				end
				kzn_pkg::MODE_CFB: begin
					fa_q <= fb_q;
					fb_q <= p_q ^ enc_out;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: sv/block_cipher_128_modes_encrypt_top.sv
// GOST 34.12-2015 (Kuznyechik) encryption with ECB, CTR, OFB, CBC and CFB chaining.
// A processed block runs eight rounds and then the ninth round with the final key
// XOR, all through one shared S-box/linear-transform unit, one round a cycle. The
// controller returns to idle as the result appears, so the next item can then be
// taken; a new block is not taken while one is still in its rounds. If the previous
// result is still waiting, the last round holds until the output register is free.
// Loads of feedback slots are taken without running the rounds. After reset, and
// after each key word write, the same round unit runs key expansion. No item is
// accepted during that time. A finished result waits in the output register while
// the next item is taken.
// Depends on kzn_pkg, kzn_if, kzn_ctrl and kzn_dpath.
`default_nettype none
module block_cipher_128_modes_encrypt_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [63:0] cfg_data,
	kzn_in_if.sink           in_ch,
	kzn_out_if.source        out_ch
);
	kzn_pkg::cmd_t  cmd;
	kzn_pkg::stat_t stat;
	logic           key_wr;

	// Any key word write restarts expansion
	assign key_wr = cfg_we && (cfg_idx < kzn_pkg::REG_MODE);

	kzn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_wr    (key_wr),
		.in_valid  (in_ch.valid),
		.in_func   (in_ch.func),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	kzn_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.func        (in_ch.func),
		.block_high  (in_ch.block_high),
		.block_low   (in_ch.block_low),
		.cmd         (cmd),
		.stat        (stat),
		.result_high (out_ch.result_high),
		.result_low  (out_ch.result_low)
	);
endmodule
`default_nettype wire

FILE: sv/kzn_chk.sv
// Port-level checker for the encryption block, bound to the top level.
// Depends on kzn_pkg.
`default_nettype none
module kzn_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_we,
	input wire logic [2:0]  cfg_idx,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] out_high,
	input wire logic [63:0] out_low
);
	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
		else $error("stalled result changed");

	// Key write starts expansion, no item accepted next cycle
	a_key_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_idx < kzn_pkg::REG_MODE) |=> !in_ready)
		else $error("item accepted during key expansion");

	// A new result only appears while the block is busy
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without encryption");
endmodule

bind block_cipher_128_modes_encrypt_top kzn_chk u_kzn_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_idx   (cfg_idx),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_high  (out_ch.result_high),
	.out_low   (out_ch.result_low)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the GOST 34.12-2015 encryption block with chaining modes.
// Predicts every result from its own key schedule and feedback mirror and checks in order.
// Depends on kzn_pkg, kzn_if and block_cipher_128_modes_encrypt_top.
module tb_top;
	import kzn_pkg::*;

	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam logic [1:0] FN_SPARE = 2'd3;

	typedef struct {
		logic [1:0]  func;
		logic [63:0] hi;
		logic [63:0] lo;
	} blk_item_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [63:0] cfg_data;
	logic        no_idle;
	int          n_fail;

	kzn_in_if  in_ch ();
	kzn_out_if out_ch ();

	block_cipher_128_modes_encrypt_top uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	blk_item_t    pend_items [$];
	logic [127:0] cipher_exp [$];

	// Mirror of the block's configuration and chaining state
	logic [63:0]  key_mirror [4];
	logic [2:0]   mode_mirror;
	logic [127:0] rkeys [10];
	logic [63:0]  chain [4];

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= a;
			a = a[7] ? ((a << 1) ^ 8'hC3) : (a << 1);
		end
		return acc;
	endfunction

	// Sixteen LFSR steps: new byte enters at byte 0
	function automatic blk_t lfsr_mix(input blk_t x);
		logic [7:0] s;
		for (int r = 0; r < 16; r++) begin
			s = '0;
			for (int i = 0; i < 16; i++) s ^= gmul(x[i], LIN_COEF[i]);
			x = {s, x[0:14]};
		end
		return x;
	endfunction

	function automatic blk_t lsx(input blk_t x, input blk_t k);
		for (int i = 0; i < 16; i++) x[i] = PI[x[i] ^ k[i]];
		return lfsr_mix(x);
	endfunction

	function automatic logic [127:0] encipher(input logic [127:0] p);
		blk_t b;
		b = p;
		for (int r = 0; r < 9; r++) b = lsx(b, rkeys[r]);
		return b ^ rkeys[9];
	endfunction

	// Key schedule: 32 Feistel steps, a pair of round keys every eight
	task automatic rebuild_keys();
		blk_t a, b, c, t;
		a = {key_mirror[0], key_mirror[1]};
		b = {key_mirror[2], key_mirror[3]};
		rkeys[0] = a;
		rkeys[1] = b;
		for (int j = 0; j < 32; j++) begin
			c = '0;
			c[15] = 8'(j + 1);
			c = lfsr_mix(c);
			t = a;
			a = lsx(a, c) ^ b;
			b = t;
			if (j % 8 == 7) begin
				rkeys[2 + 2 * (j / 8)] = a;
				rkeys[3 + 2 * (j / 8)] = b;
			end
		end
	endtask

	// Apply one accepted item to the mirror and queue its ciphertext, if any
	task automatic advance(input logic [1:0] fn, input logic [63:0] hi, input logic [63:0] lo);
		logic [127:0] p, e, r, a;
		p = {hi, lo};
		a = {chain[0], chain[1]};
		if (fn == FN_LOADA) begin
			chain[0] = hi;
			chain[1] = (mode_mirror == MODE_CTR) ? 64'd0 : lo;
		end else if (fn == FN_LOADB) begin
			chain[2] = hi;
			chain[3] = lo;
		end else if (fn == FN_BLOCK && mode_mirror <= MODE_CFB) begin
			case (mode_mirror)
				MODE_ECB: r = encipher(p);
				MODE_CBC: r = encipher(p ^ a);
				default: begin
					e = encipher(a);
					r = p ^ e;
				end
			endcase
			if (mode_mirror == MODE_CTR) begin
				chain[1] = chain[1] + 64'd1;
				if (chain[1] == 64'd0)
					chain[0] = {chain[0][63:56], chain[0][55:0] + 56'd1};
			end else if (mode_mirror != MODE_ECB) begin
				chain[0] = chain[2];
				chain[1] = chain[3];
				{chain[2], chain[3]} = (mode_mirror == MODE_OFB) ? e : r;
			end
			cipher_exp.push_back(r);
		end
	endtask

	task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
		$display("%0t: mismatch %s: got %h want %h", $realtime, what, got, want);
		n_fail++;
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Input driver: predicts on acceptance, then offers the next pending item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.func <= FN_BLOCK;
			in_ch.block_high <= '0;
			in_ch.block_low <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				advance(in_ch.func, in_ch.block_high, in_ch.block_low);
			if (!in_ch.valid || in_ch.ready) begin
				if (pend_items.size() > 0 && (no_idle || $urandom_range(99) >= 12)) begin
					in_ch.valid <= 1'b1;
					in_ch.func <= pend_items[0].func;
					in_ch.block_high <= pend_items[0].hi;
					in_ch.block_low <= pend_items[0].lo;
					void'(pend_items.pop_front());
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= no_idle || ($urandom_range(99) >= 12);
			if (out_ch.valid && out_ch.ready) begin
				if (cipher_exp.size() == 0)
					report("unexpected item", {out_ch.result_high, out_ch.result_low}, '0);
				else begin
					if (out_ch.result_high !== cipher_exp[0][127:64])
						report("result_high", 128'(out_ch.result_high),
							128'(cipher_exp[0][127:64]));
					if (out_ch.result_low !== cipher_exp[0][63:0])
						report("result_low", 128'(out_ch.result_low),
							128'(cipher_exp[0][63:0]));
					void'(cipher_exp.pop_front());
				end
			end
		end
	end

	function automatic logic [63:0] rnd64();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0) return '0;
		if (pick == 1) return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic push_item(input logic [1:0] fn, input logic [63:0] hi, input logic [63:0] lo);
		blk_item_t it;
		it.func = fn;
		it.hi = hi;
		it.lo = lo;
		pend_items.push_back(it);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MODE) mode_mirror = val[2:0];
		else begin
			key_mirror[idx[1:0]] = val;
			rebuild_keys();
		end
	endtask

	task automatic drain();
		while (pend_items.size() > 0 || in_ch.valid || cipher_exp.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Mostly well-formed chains: both slots loaded, then blocks with occasional reloads
	task automatic random_phase(input int n);
		int pick;
		push_item(FN_LOADA, rnd64(), rnd64());
		push_item(FN_LOADB, rnd64(), rnd64());
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 85) push_item(FN_BLOCK, rnd64(), rnd64());
			else if (pick < 91) push_item(FN_LOADA, rnd64(), rnd64());
			else if (pick < 96) push_item(FN_LOADB, rnd64(), rnd64());
			else push_item(FN_SPARE, rnd64(), rnd64());
		end
	endtask

	// Stimulus
	initial begin
		logic [2:0] mode_list [14];
		mode_list = '{MODE_ECB, MODE_CTR, MODE_OFB, MODE_CBC, MODE_CFB, MODE_SPARE_LO,
			MODE_CTR, MODE_CBC, MODE_OFB, MODE_SPARE_HI, MODE_CFB, MODE_ECB,
			MODE_CBC, MODE_CTR};
		n_fail = 0;
		no_idle = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_KEY0;
		cfg_data = '0;
		mode_mirror = MODE_ECB;
		for (int i = 0; i < 4; i++) begin
			key_mirror[i] = '0;
			chain[i] = '0;
		end
		rebuild_keys();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero key after reset, extreme blocks, loads and the unused function
		push_item(FN_BLOCK, '0, '0);
		push_item(FN_BLOCK, '1, '1);
		push_item(FN_BLOCK, 64'h8000000000000000, 64'h0000000000000001);
		push_item(FN_SPARE, '1, '1);
		push_item(FN_LOADA, '1, '1);
		push_item(FN_LOADB, '1, '0);
		push_item(FN_BLOCK, 64'h1122334455667700, 64'hffeeddccbbaa9988);
		drain();
		write_reg(REG_MODE, MODE_CTR);
		// Counter load drops the low word; blocks then step the counter
		push_item(FN_LOADA, '1, '1);
		push_item(FN_BLOCK, '0, '0);
		push_item(FN_BLOCK, '1, '1);
		push_item(FN_LOADB, '1, '1);
		push_item(FN_BLOCK, '0, '1);
		drain();
		write_reg(REG_MODE, MODE_SPARE_HI);
		push_item(FN_BLOCK, '1, '1);
		push_item(FN_LOADA, 64'h0123456789abcdef, 64'hfedcba9876543210);
		drain();
		write_reg(REG_MODE, MODE_OFB);
		push_item(FN_BLOCK, '0, '0);
		push_item(FN_BLOCK, '1, '0);
		drain();

		// Random phases across key and mode settings
		for (int ph = 0; ph < 14; ph++) begin
			for (int k = 0; k < 4; k++)
				write_reg(k[2:0], (ph == 2) ? '1 : (ph == 3) ? '0 : rnd64());
			write_reg(REG_MODE, mode_list[ph]);
			no_idle = (ph == 7);
			random_phase(100);
			drain();
		end

		if (n_fail == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#6_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
